// ===== hw/rtl/acsfr_pkg.sv =====
// Shared types, codes and constants for the AC status frame receiver.
package acsfr_pkg;

  // Defaults
  localparam int unsigned MAX_FRAME_BYTES_DEF = 128;
  localparam logic [7:0]  HEADER_RST          = 8'd187;
  localparam logic [15:0] TIMEOUT_RST         = 16'd50;

  // Framing
  localparam int unsigned LEN_POS          = 4;
  localparam int unsigned FRAME_OVERHEAD   = 6;
  localparam int unsigned MIN_STATUS_BYTES = 61;
  localparam logic [7:0]  TYPE_STATUS_A    = 8'h03;
  localparam logic [7:0]  TYPE_STATUS_B    = 8'h04;

  // Frame positions that are kept
  localparam int unsigned POS_TYPE  = 3;
  localparam int unsigned POS_MODE  = 7;
  localparam int unsigned POS_FAN   = 8;
  localparam int unsigned POS_FLAGS = 9;
  localparam int unsigned POS_SWING = 10;
  localparam int unsigned POS_TEMPH = 17;
  localparam int unsigned POS_TEMPL = 18;
  localparam int unsigned POS_SLEEP = 19;
  localparam int unsigned POS_VERT  = 32;
  localparam int unsigned POS_HORIZ = 33;

  // Room temperature scaling: round((raw - 11968) * 40 / 1683)
  localparam logic [16:0] ROOM_OFFSET = 17'd11968;
  localparam logic [21:0] ROOM_ROUND  = 22'd841;
  localparam logic [22:0] ROOM_RECIP  = 23'd5103943;  // ceil(2^33 / 1683)
  localparam int unsigned ROOM_SHIFT  = 33;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    CFG_HEADER  = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_e;

  // Mode codes (byte 7 low nibble) and decoded values
  localparam logic [3:0] MODE_CODE_AUTO = 4'h5;
  localparam logic [3:0] MODE_CODE_COOL = 4'h1;
  localparam logic [3:0] MODE_CODE_HEAT = 4'h4;
  localparam logic [3:0] MODE_CODE_DRY  = 4'h3;
  localparam logic [3:0] MODE_CODE_FAN  = 4'h2;
  localparam logic [2:0] MODE_AUTO = 3'd0;
  localparam logic [2:0] MODE_COOL = 3'd1;
  localparam logic [2:0] MODE_HEAT = 3'd2;
  localparam logic [2:0] MODE_DRY  = 3'd3;
  localparam logic [2:0] MODE_FAN  = 3'd4;

  // Fan codes (byte 8 high nibble)
  localparam logic [3:0] FAN_CODE_AUTO = 4'h8;
  localparam logic [3:0] FAN_CODE_1    = 4'h9;
  localparam logic [3:0] FAN_CODE_2    = 4'hC;
  localparam logic [3:0] FAN_CODE_3    = 4'hA;
  localparam logic [3:0] FAN_CODE_4    = 4'hD;
  localparam logic [3:0] FAN_CODE_5    = 4'hB;

  localparam logic [7:0] VERT_MIN  = 8'h01;
  localparam logic [7:0] VERT_MAX  = 8'h05;
  localparam logic [7:0] HORIZ_MIN = 8'h81;
  localparam logic [7:0] HORIZ_MAX = 8'h85;

  typedef struct packed {
    logic [7:0] b3;
    logic [7:0] b7;
    logic [7:0] b8;
    logic [7:0] b9;
    logic [7:0] b10;
    logic [7:0] b19;
    logic [7:0] b32;
    logic [7:0] b33;
  } capt_t;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] fan;
    logic [1:0] sleep;
    logic [2:0] vert;
    logic [2:0] horiz;
  } last_t;

  typedef struct packed {
    logic [2:0]         frame_type;
    logic               power_on;
    logic [2:0]         op_mode;
    logic [5:0]         target_half_degrees;
    logic [2:0]         fan_level;
    logic [1:0]         swing_flags;
    logic [4:0]         feature_flags;
    logic [1:0]         sleep_level;
    logic [2:0]         vertical_position;
    logic [2:0]         horizontal_position;
    logic signed [11:0] room_sixteenths;
  } status_t;

endpackage

// ===== hw/rtl/ac_status_frame_receiver.sv =====
// Top level of the AC status frame receiver: framing, checksum and result register.
//
// Input channel (in_valid_i/in_ready_o): one beat is either a received serial
// byte (command_i = 0, rx_byte_i) or one elapsed time tick (command_i = 1).
// Output channel (out_valid_o/out_ready_i): one beat per good status frame,
// i.e. a complete frame of 61 or more bytes, type 3 or 4, good XOR checksum.
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 header byte, 1 idle timeout in ticks); write only while idle.
// Path: a beat lands in the input register, is framed from there and its status,
// if any, is registered in the output register once the output is free.
// Throughput: one beat per cycle unless the output stalls; the input and output
// registers let a new beat enter while a finished status still waits to be taken.
// The room temperature is scaled by a three-stage multiply pipeline running
// off the captured temperature bytes, long settled before the frame ends.
// Reset: no frame in progress, sticky mode/fan/sleep/louver values zero,
// registers at their defaults, output empty.
// Stall: while the output holds a status that is not taken, the input register
// holds its beat and in_ready_o drops once that register is full.
module ac_status_frame_receiver #(
  parameter int unsigned MAX_FRAME_BYTES = acsfr_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                command_i,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [2:0]          frame_type_o,
  output logic                power_on_o,
  output logic [2:0]          op_mode_o,
  output logic [5:0]          target_half_degrees_o,
  output logic [2:0]          fan_level_o,
  output logic [1:0]          swing_flags_o,
  output logic [4:0]          feature_flags_o,
  output logic [1:0]          sleep_level_o,
  output logic [2:0]          vertical_position_o,
  output logic [2:0]          horizontal_position_o,
  output logic signed [11:0]  room_sixteenths_o
);

  localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

  // Config registers
  logic [7:0]  header_q;
  logic [15:0] timeout_q;

  // Input register
  logic               in_valid_q;
  acsfr_pkg::cmd_e    in_cmd_q;
  logic [7:0]         in_byte_q;

  // Frame state
  logic [CNT_W-1:0] bc_q, bc_d, bc_inc, expected;
  logic [7:0]       xor_q, xor_d;
  logic [7:0]       len_q, len_d;
  logic [15:0]      idle_q, idle_d, idle_inc;
  acsfr_pkg::last_t last_q, last_d, dec_last;
  acsfr_pkg::capt_t capt_q;
  logic [7:0]       temp_hi_q, temp_lo_q;

  // Output register
  logic               out_valid_q;
  acsfr_pkg::status_t out_q;
  acsfr_pkg::status_t dec_status;

  logic               proc;
  logic               byte_take;
  logic               emit;
  logic               too_big;
  logic               frame_ok;
  logic signed [11:0] room;

  assign proc       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || proc;
  assign byte_take  = proc && (in_cmd_q == acsfr_pkg::CMD_BYTE)
                      && (bc_q != '0 || in_byte_q == header_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q  <= acsfr_pkg::HEADER_RST;
      timeout_q <= acsfr_pkg::TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (acsfr_pkg::cfg_idx_e'(cfg_idx_i))
        acsfr_pkg::CFG_HEADER:  header_q  <= cfg_wdata_i[7:0];
        acsfr_pkg::CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_cmd_q  <= acsfr_pkg::cmd_e'(command_i);
      in_byte_q <= rx_byte_i;
    end
  end

  acsfr_room u_room (
    .clk_i  (clk_i),
    .hi_i   (temp_hi_q),
    .lo_i   (temp_lo_q),
    .room_o (room)
  );

  acsfr_decode u_decode (
    .capt_i   (capt_q),
    .last_i   (last_q),
    .room_i   (room),
    .status_o (dec_status),
    .last_o   (dec_last)
  );

  assign bc_inc   = bc_q + 1'b1;
  assign expected = CNT_W'(len_q) + CNT_W'(acsfr_pkg::FRAME_OVERHEAD);
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
  assign too_big  = ({1'b0, in_byte_q} + 9'(acsfr_pkg::FRAME_OVERHEAD))
                    > 9'(MAX_FRAME_BYTES);
  assign frame_ok = (xor_q == in_byte_q)
                    && (bc_inc >= CNT_W'(acsfr_pkg::MIN_STATUS_BYTES))
                    && (capt_q.b3 == acsfr_pkg::TYPE_STATUS_A
                        || capt_q.b3 == acsfr_pkg::TYPE_STATUS_B);

  always_comb begin
    bc_d   = bc_q;
    xor_d  = xor_q;
    len_d  = len_q;
    idle_d = idle_q;
    last_d = last_q;
    emit   = 1'b0;
    if (proc && in_cmd_q == acsfr_pkg::CMD_TICK) begin
      if (bc_q != '0) begin
        idle_d = idle_inc;
        if (idle_inc > timeout_q) begin
          bc_d   = '0;
          xor_d  = '0;
          len_d  = '0;
          idle_d = '0;
        end
      end
    end else if (byte_take) begin
      bc_d   = bc_inc;
      idle_d = '0;
      if (bc_q == CNT_W'(acsfr_pkg::LEN_POS)) begin
        len_d = in_byte_q;
        xor_d = xor_q ^ in_byte_q;
        if (too_big) begin
          bc_d  = '0;
          xor_d = '0;
          len_d = '0;
        end
      end else if (bc_q < CNT_W'(acsfr_pkg::LEN_POS) || bc_inc < expected) begin
        xor_d = xor_q ^ in_byte_q;
      end else begin
        // last byte is the checksum
        if (frame_ok) begin
          emit   = 1'b1;
          last_d = dec_last;
        end
        bc_d  = '0;
        xor_d = '0;
        len_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q   <= '0;
      xor_q  <= '0;
      len_q  <= '0;
      idle_q <= '0;
      last_q <= '0;
    end else begin
      bc_q   <= bc_d;
      xor_q  <= xor_d;
      len_q  <= len_d;
      idle_q <= idle_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_take) begin
      unique case (int'(bc_q))
        acsfr_pkg::POS_TYPE:  capt_q.b3  <= in_byte_q;
        acsfr_pkg::POS_MODE:  capt_q.b7  <= in_byte_q;
        acsfr_pkg::POS_FAN:   capt_q.b8  <= in_byte_q;
        acsfr_pkg::POS_FLAGS: capt_q.b9  <= in_byte_q;
        acsfr_pkg::POS_SWING: capt_q.b10 <= in_byte_q;
        acsfr_pkg::POS_TEMPH: temp_hi_q  <= in_byte_q;
        acsfr_pkg::POS_TEMPL: temp_lo_q  <= in_byte_q;
        acsfr_pkg::POS_SLEEP: capt_q.b19 <= in_byte_q;
        acsfr_pkg::POS_VERT:  capt_q.b32 <= in_byte_q;
        acsfr_pkg::POS_HORIZ: capt_q.b33 <= in_byte_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= emit;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= dec_status;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign frame_type_o          = out_q.frame_type;
  assign power_on_o            = out_q.power_on;
  assign op_mode_o             = out_q.op_mode;
  assign target_half_degrees_o = out_q.target_half_degrees;
  assign fan_level_o           = out_q.fan_level;
  assign swing_flags_o         = out_q.swing_flags;
  assign feature_flags_o       = out_q.feature_flags;
  assign sleep_level_o         = out_q.sleep_level;
  assign vertical_position_o   = out_q.vertical_position;
  assign horizontal_position_o = out_q.horizontal_position;
  assign room_sixteenths_o     = out_q.room_sixteenths;

  // Assertions
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(bc_q) < MAX_FRAME_BYTES)
    else $error("frame byte count out of range");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_valid_o && bc_q == '0)
    else $error("status beat not presented or frame not cleared");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> in_valid_q && out_valid_o && !out_ready_i)
    else $error("input stalled without a blocked output");

  a_idle_hunting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q == '0 |-> xor_q == '0 && len_q == '0 && idle_q == '0)
    else $error("frame state left over while hunting");

endmodule

// ===== hw/rtl/acsfr_room.sv =====
// Pipelined room temperature scaler: reciprocal multiply replaces the divide.
module acsfr_room (
  input  logic                clk_i,
  input  logic [7:0]          hi_i,
  input  logic [7:0]          lo_i,
  output logic signed [11:0]  room_o
);

  logic [16:0] diff;
  logic        neg;
  logic [15:0] mag;
  logic [21:0] x_d;
  logic [21:0] x_q;
  logic        neg_q;
  logic [44:0] prod_q;
  logic        neg2_q;
  logic [10:0] quot;
  logic signed [11:0] room_q;

  always_comb begin
    diff = {1'b0, hi_i, lo_i} - acsfr_pkg::ROOM_OFFSET;
    neg  = diff[16];
    mag  = neg ? 16'(-diff) : diff[15:0];
    x_d  = ({6'b0, mag} << 5) + ({6'b0, mag} << 3) + acsfr_pkg::ROOM_ROUND;
  end

  assign quot = prod_q[acsfr_pkg::ROOM_SHIFT +: 11];

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    neg_q  <= neg;
    prod_q <= 45'(x_q) * 45'(acsfr_pkg::ROOM_RECIP);
    neg2_q <= neg_q;
    room_q <= neg2_q ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  end

  assign room_o = room_q;

endmodule

// ===== hw/rtl/acsfr_decode.sv =====
// Status field decode from captured frame bytes, with sticky last values.
module acsfr_decode (
  input  acsfr_pkg::capt_t    capt_i,
  input  acsfr_pkg::last_t    last_i,
  input  logic signed [11:0]  room_i,
  output acsfr_pkg::status_t  status_o,
  output acsfr_pkg::last_t    last_o
);

  always_comb begin
    last_o = last_i;

    case (capt_i.b7[3:0])
      acsfr_pkg::MODE_CODE_AUTO: last_o.mode = acsfr_pkg::MODE_AUTO;
      acsfr_pkg::MODE_CODE_COOL: last_o.mode = acsfr_pkg::MODE_COOL;
      acsfr_pkg::MODE_CODE_HEAT: last_o.mode = acsfr_pkg::MODE_HEAT;
      acsfr_pkg::MODE_CODE_DRY:  last_o.mode = acsfr_pkg::MODE_DRY;
      acsfr_pkg::MODE_CODE_FAN:  last_o.mode = acsfr_pkg::MODE_FAN;
      default: ;
    endcase

    case (capt_i.b8[7:4])
      acsfr_pkg::FAN_CODE_AUTO: last_o.fan = 3'd0;
      acsfr_pkg::FAN_CODE_1:    last_o.fan = 3'd1;
      acsfr_pkg::FAN_CODE_2:    last_o.fan = 3'd2;
      acsfr_pkg::FAN_CODE_3:    last_o.fan = 3'd3;
      acsfr_pkg::FAN_CODE_4:    last_o.fan = 3'd4;
      acsfr_pkg::FAN_CODE_5:    last_o.fan = 3'd5;
      default: ;
    endcase

    if (capt_i.b19[7:6] != 2'd0) begin
      last_o.sleep = capt_i.b19[7:6];
    end
    if (capt_i.b32 >= acsfr_pkg::VERT_MIN && capt_i.b32 <= acsfr_pkg::VERT_MAX) begin
      last_o.vert = capt_i.b32[2:0];
    end
    if (capt_i.b33 >= acsfr_pkg::HORIZ_MIN && capt_i.b33 <= acsfr_pkg::HORIZ_MAX) begin
      last_o.horiz = capt_i.b33[2:0];
    end

    status_o.frame_type          = capt_i.b3[2:0];
    status_o.power_on            = capt_i.b7[4];
    status_o.op_mode             = last_o.mode;
    status_o.target_half_degrees = {1'b1, capt_i.b8[3:0], capt_i.b9[1]};
    status_o.fan_level           = last_o.fan;
    status_o.swing_flags         = capt_i.b10[6:5];
    status_o.feature_flags       = {capt_i.b33[7], capt_i.b9[2], capt_i.b7[7:5]};
    status_o.sleep_level         = last_o.sleep;
    status_o.vertical_position   = last_o.vert;
    status_o.horizontal_position = last_o.horiz;
    status_o.room_sixteenths     = room_i;
  end

endmodule
